// ----- hdl/usv_pkg.sv -----
// shared types, codes and the crc step for the upload session verifier
package usv_pkg;

  // request codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_CHUNK = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // response status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_SESSION = 3'd1;
  localparam logic [2:0] ST_BAD_FRAME  = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE  = 3'd3;
  localparam logic [2:0] ST_STORE_ERR  = 3'd4;
  localparam logic [2:0] ST_CRC_BAD    = 3'd5;

  // store outcome code for an oversized upload
  localparam logic [1:0] SST_TOO_LARGE = 2'd1;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [23:0] upload_len;
    logic [31:0] expected_crc;
    logic [23:0] chunk_offset;
    logic [7:0]  data_byte;
    logic        chunk_first;
    logic        chunk_last;
    logic [1:0]  store_status;
  } req_t;

  typedef struct packed {
    logic [1:0]  resp_op;
    logic [2:0]  status;
    logic [23:0] progress;
  } resp_t;

  // classified beat as held in the queue
  typedef struct packed {
    logic        is_start;
    logic        is_chunk;
    logic        is_end;
    logic        st_fail;
    logic        st_big;
    logic [23:0] upload_len;
    logic [31:0] expected_crc;
    logic [23:0] chunk_offset;
    logic [7:0]  data_byte;
    logic        chunk_first;
    logic        chunk_last;
  } item_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] r, input logic [7:0] b);
    logic [31:0] v;
    v = r ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

endpackage

// ----- hdl/usv_chan_if.sv -----
// valid/ready channel carrying one payload beat
interface usv_chan_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- hdl/usv_front.sv -----
// front end: takes request beats, classifies them and pushes into the queue
module usv_front (
  usv_chan_if.sink        req,
  output usv_pkg::item_t  item,
  output logic            push,
  input  logic            full
);
  import usv_pkg::*;

  logic known;

  // unknown request codes are taken and dropped here
  assign known     = req.data.req_type inside {OP_START, OP_CHUNK, OP_END};
  assign req.ready = !full;
  assign push      = req.valid && !full && known;

  always_comb begin
    item.is_start     = (req.data.req_type == OP_START);
    item.is_chunk     = (req.data.req_type == OP_CHUNK);
    item.is_end       = (req.data.req_type == OP_END);
    item.st_fail      = (req.data.store_status != 2'd0);
    item.st_big       = (req.data.store_status == SST_TOO_LARGE);
    item.upload_len   = req.data.upload_len;
    item.expected_crc = req.data.expected_crc;
    item.chunk_offset = req.data.chunk_offset;
    item.data_byte    = req.data.data_byte;
    item.chunk_first  = req.data.chunk_first;
    item.chunk_last   = req.data.chunk_last;
  end
endmodule

// ----- hdl/usv_queue.sv -----
// short queue between front and back
module usv_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  usv_pkg::item_t  wr_item,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output usv_pkg::item_t  head
);
  import usv_pkg::*;

  item_t                mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_BITS+1)'(do_push) - (QPTR_BITS+1)'(do_pop);
    end
  end
endmodule

// ----- hdl/usv_back.sv -----
// back end: session state, crc and the registered response beat
module usv_back #(
  parameter int CHUNK_MAX = 196,
  parameter int LEN_BITS  = 24
) (
  input  logic            clk,
  input  logic            rst,
  input  usv_pkg::item_t  head,
  input  logic            empty,
  output logic            pop,
  usv_chan_if.source      resp
);
  import usv_pkg::*;

  localparam int CW = $clog2(CHUNK_MAX + 1);
  localparam int WB = (LEN_BITS > 24) ? LEN_BITS : 24;

  logic                active, active_next;
  logic                discarding, discarding_next;
  logic [LEN_BITS-1:0] len_exp, len_exp_next;
  logic [31:0]         crc_exp, crc_exp_next;
  logic [31:0]         crc, crc_next;
  logic [LEN_BITS-1:0] offset, offset_next;
  logic [CW-1:0]       cnt, cnt_next;

  logic                out_valid;
  resp_t               out_data;
  logic                emit;
  resp_t               emit_data;

  logic [CW-1:0]       cnt_eff;
  logic [LEN_BITS-1:0] offset_inc;
  logic [31:0]         crc_upd;
  logic                bad;

  assign pop        = !empty && (!out_valid || resp.ready);
  assign resp.valid = out_valid;
  assign resp.data  = out_data;

  assign cnt_eff    = head.chunk_first ? '0 : cnt;
  assign offset_inc = offset + 1'b1;
  assign crc_upd    = crc_byte(crc, head.data_byte);
  assign bad        = (head.chunk_first && (WB'(head.chunk_offset) != WB'(offset)))
                      || (cnt_eff >= CW'(CHUNK_MAX));

  always_comb begin
    active_next     = active;
    discarding_next = discarding;
    len_exp_next    = len_exp;
    crc_exp_next    = crc_exp;
    crc_next        = crc;
    offset_next     = offset;
    cnt_next        = cnt;
    emit            = 1'b0;
    emit_data       = '0;

    if (head.is_start) begin
      discarding_next = 1'b0;
      active_next     = !head.st_fail;
      len_exp_next    = head.st_fail ? '0 : LEN_BITS'(head.upload_len);
      crc_exp_next    = head.st_fail ? '0 : head.expected_crc;
      crc_next        = CRC_INIT;
      offset_next     = '0;
      cnt_next        = '0;
      emit            = 1'b1;
      emit_data       = '{resp_op: OP_START,
                          status: head.st_fail ? ST_STORE_ERR : ST_OK,
                          progress: 24'd0};
    end else if (head.is_chunk) begin
      if (discarding) begin
        if (head.chunk_last) discarding_next = 1'b0;
      end else if (!active) begin
        emit      = head.chunk_last;
        emit_data = '{resp_op: OP_CHUNK, status: ST_NO_SESSION, progress: 24'd0};
      end else if (bad) begin
        active_next     = 1'b0;
        len_exp_next    = '0;
        crc_exp_next    = '0;
        crc_next        = CRC_INIT;
        offset_next     = '0;
        cnt_next        = '0;
        discarding_next = !head.chunk_last;
        emit            = 1'b1;
        emit_data       = '{resp_op: OP_CHUNK, status: ST_BAD_FRAME,
                            progress: 24'(offset)};
      end else begin
        crc_next    = crc_upd;
        offset_next = offset_inc;
        cnt_next    = cnt_eff + 1'b1;
        if (head.chunk_last) begin
          cnt_next = '0;
          emit     = 1'b1;
          if (head.st_fail) begin
            active_next  = 1'b0;
            len_exp_next = '0;
            crc_exp_next = '0;
            crc_next     = CRC_INIT;
            offset_next  = '0;
            emit_data    = '{resp_op: OP_CHUNK,
                             status: head.st_big ? ST_TOO_LARGE : ST_STORE_ERR,
                             progress: 24'd0};
          end else begin
            emit_data = '{resp_op: OP_CHUNK, status: ST_OK,
                          progress: 24'(offset_inc)};
          end
        end
      end
    end else if (head.is_end) begin
      discarding_next = 1'b0;
      emit            = 1'b1;
      if (!active) begin
        emit_data = '{resp_op: OP_END, status: ST_NO_SESSION, progress: 24'd0};
      end else begin
        active_next  = 1'b0;
        len_exp_next = '0;
        crc_exp_next = '0;
        crc_next     = CRC_INIT;
        offset_next  = '0;
        cnt_next     = '0;
        if (offset != len_exp) begin
          emit_data = '{resp_op: OP_END, status: ST_BAD_FRAME, progress: 24'(offset)};
        end else if (~crc != crc_exp) begin
          emit_data = '{resp_op: OP_END, status: ST_CRC_BAD, progress: 24'd0};
        end else begin
          emit_data = '{resp_op: OP_END,
                        status: head.st_fail ? ST_STORE_ERR : ST_OK,
                        progress: 24'd0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      discarding <= 1'b0;
      len_exp    <= '0;
      crc_exp    <= '0;
      crc        <= CRC_INIT;
      offset     <= '0;
      cnt        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (resp.ready) out_valid <= 1'b0;
      if (pop) begin
        active     <= active_next;
        discarding <= discarding_next;
        len_exp    <= len_exp_next;
        crc_exp    <= crc_exp_next;
        crc        <= crc_next;
        offset     <= offset_next;
        cnt        <= cnt_next;
        if (emit) out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_data <= emit_data;
    end
  end
endmodule

// ----- hdl/upload_session_verifier_top.sv -----
// upload session verifier: chunked upload check with running offset and crc-32
// a request beat is written into the queue, and any response beat it gives is registered as the back end pops it
// throughput: one request beat per cycle while the queue is not full, set by the byte-wide crc step in the back end
// the four-entry queue lets requests keep flowing while a response beat waits
// reset (rst, synchronous): no session, not discarding, crc all ones, queue empty
module upload_session_verifier_top #(
  parameter int CHUNK_MAX = 196,
  parameter int LEN_BITS  = 24
) (
  input  logic       clk,
  input  logic       rst,
  usv_chan_if.sink   req,
  usv_chan_if.source resp
);
  import usv_pkg::*;

  // classified beat from front to queue
  item_t push_item;
  logic  push;
  logic  full;

  // head of the queue to the back end
  item_t head_item;
  logic  pop;
  logic  empty;

  // front end decodes the request and drops unknown codes
  usv_front u_front (
    .req  (req),
    .item (push_item),
    .push (push),
    .full (full)
  );

  // decoupling queue, so the front keeps taking beats while the back stalls, until the queue is full
  usv_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (push_item),
    .full    (full),
    .pop     (pop),
    .empty   (empty),
    .head    (head_item)
  );

  // back end runs the session, crc update and checks, and registers the response
  usv_back #(
    .CHUNK_MAX (CHUNK_MAX),
    .LEN_BITS  (LEN_BITS)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head_item),
    .empty (empty),
    .pop   (pop),
    .resp  (resp)
  );
endmodule
